// ===== rtl/core/npc_pkg.sv =====
// ----------------------------------------------------------------------------
// npc_pkg
// Shared types and constants of the non-overlapping pattern counter.
// ----------------------------------------------------------------------------
package npc_pkg;

	localparam int BYTE_W      = 8;
	localparam int PAT_BYTES   = 16;
	localparam int PAT_W       = PAT_BYTES * BYTE_W;
	localparam int CFG_DATA_W  = 64;
	localparam int CFG_IDX_W   = 2;
	localparam int LEN_FIELD_W = 5;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PAT_LO  = 2'd0,
		CFG_PAT_HI  = 2'd1,
		CFG_PAT_LEN = 2'd2
	} cfg_idx_t;

	// one classified text byte on its way from the front to the back
	typedef struct packed {
		logic hit;
		logic last;
	} q_entry_t;

endpackage

// ===== rtl/core/npc_ifs.sv =====
// ----------------------------------------------------------------------------
// npc interfaces
// Valid/ready channels for text bytes, counts and register writes.
// ----------------------------------------------------------------------------
interface npc_in_if;
	logic                         valid;
	logic                         ready;
	logic [npc_pkg::BYTE_W-1:0]   text_byte;
	logic                         end_of_text;

	modport source(output valid, output text_byte, output end_of_text, input ready);
	modport sink(input valid, input text_byte, input end_of_text, output ready);
endinterface

interface npc_out_if #(parameter int COUNT_WIDTH = 32);
	logic                   valid;
	logic                   ready;
	logic [COUNT_WIDTH-1:0] match_count;

	modport source(output valid, output match_count, input ready);
	modport sink(input valid, input match_count, output ready);
endinterface

interface npc_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [npc_pkg::CFG_IDX_W-1:0]    index;
	logic [npc_pkg::CFG_DATA_W-1:0]   data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/npc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// npc_cfg_regs
// Pattern and length registers; gives the length clamped to MAX_PATTERN.
// ----------------------------------------------------------------------------
module npc_cfg_regs #(
	parameter int MAX_PATTERN = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	npc_cfg_if.sink                             cfg,
	output logic [npc_pkg::PAT_W-1:0]           pattern,
	output logic [$clog2(MAX_PATTERN+1)-1:0]    len_eff
);
	import npc_pkg::*;

	localparam int LEN_W = $clog2(MAX_PATTERN + 1);

	logic [CFG_DATA_W-1:0]  pat_lo_q;
	logic [CFG_DATA_W-1:0]  pat_hi_q;
	logic [LEN_FIELD_W-1:0] len_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_lo_q <= '0;
			pat_hi_q <= '0;
			len_q    <= '0;
		end else if (cfg.valid) begin
			unique case (cfg_idx_t'(cfg.index))
				CFG_PAT_LO:  pat_lo_q <= cfg.data;
				CFG_PAT_HI:  pat_hi_q <= cfg.data;
				CFG_PAT_LEN: len_q    <= cfg.data[LEN_FIELD_W-1:0];
				default: ;
			endcase
		end
	end

	assign pattern = {pat_hi_q, pat_lo_q};
	assign len_eff = (int'(len_q) > MAX_PATTERN) ? LEN_W'(MAX_PATTERN) : LEN_W'(len_q);

endmodule

// ===== rtl/core/npc_front.sv =====
// ----------------------------------------------------------------------------
// npc_front
// Accepts text bytes, keeps the byte window and flags bytes that end a match.
// ----------------------------------------------------------------------------
module npc_front #(
	parameter int MAX_PATTERN = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [npc_pkg::PAT_W-1:0]           pattern,
	input  logic [$clog2(MAX_PATTERN+1)-1:0]    len_eff,
	npc_in_if.sink                              in_ch,
	input  logic                                q_full,
	output logic                                push,
	output npc_pkg::q_entry_t                   push_entry
);
	import npc_pkg::*;

	localparam int LEN_W = $clog2(MAX_PATTERN + 1);
	localparam int WIN_D = (MAX_PATTERN > 1) ? MAX_PATTERN - 1 : 1;
	localparam int IDX_W = (LEN_W > 5) ? LEN_W : 5;

	logic [BYTE_W-1:0] recent_q [WIN_D];
	logic [LEN_W-1:0]  seen_q;
	logic [LEN_W-1:0]  seen_inc;
	logic [BYTE_W-1:0] pat_bytes [PAT_BYTES];
	logic [BYTE_W-1:0] win_byte [MAX_PATTERN];
	logic [MAX_PATTERN-1:0] lane_ok;
	logic hit;

	assign in_ch.ready = !q_full;
	assign push        = in_ch.valid && !q_full;

	for (genvar b = 0; b < PAT_BYTES; b++) begin : g_pat
		assign pat_bytes[b] = pattern[b*BYTE_W +: BYTE_W];
	end

	// lane j compares the j-th newest byte with pattern byte len-1-j
	for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_lane
		logic [IDX_W-1:0]  idx;
		logic [BYTE_W-1:0] pbyte;
		logic              in_use;

		if (j == 0) begin : g_cur
			assign win_byte[j] = in_ch.text_byte;
		end else begin : g_old
			assign win_byte[j] = recent_q[j-1];
		end

		assign idx    = IDX_W'(len_eff) - IDX_W'(j + 1);
		assign in_use = LEN_W'(j) < len_eff;
		assign pbyte  = (idx < IDX_W'(PAT_BYTES)) ? pat_bytes[idx[3:0]] : '0;
		assign lane_ok[j] = !in_use || (pbyte == win_byte[j]);
	end

	assign seen_inc = (seen_q == LEN_W'(MAX_PATTERN)) ? seen_q : seen_q + 1'b1;
	assign hit      = (len_eff != '0) && (seen_inc >= len_eff) && (&lane_ok);

	assign push_entry.hit  = hit;
	assign push_entry.last = in_ch.end_of_text;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
		end else if (push) begin
			seen_q <= in_ch.end_of_text ? '0 : seen_inc;
		end
	end

	// window bytes are only compared once this text has filled them
	always_ff @(posedge clk) begin
		if (push) begin
			recent_q[0] <= in_ch.text_byte;
			for (int i = 1; i < WIN_D; i++) begin
				recent_q[i] <= recent_q[i-1];
			end
		end
	end

endmodule

// ===== rtl/core/npc_queue.sv =====
// ----------------------------------------------------------------------------
// npc_queue
// Short FIFO of classified bytes between the front and the back.
// ----------------------------------------------------------------------------
module npc_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  npc_pkg::q_entry_t push_entry,
	output logic              full,
	input  logic              pop,
	output logic              pop_valid,
	output npc_pkg::q_entry_t pop_entry
);
	import npc_pkg::*;

	q_entry_t          slots_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full      = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign pop_valid = (cnt_q != '0);
	assign pop_entry = slots_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_q] <= push_entry;
		end
	end

endmodule

// ===== rtl/core/npc_back.sv =====
// ----------------------------------------------------------------------------
// npc_back
// Applies the non-overlap skip, counts matches and issues the count beat.
// ----------------------------------------------------------------------------
module npc_back #(
	parameter int MAX_PATTERN = 16,
	parameter int COUNT_WIDTH = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [$clog2(MAX_PATTERN+1)-1:0]    len_eff,
	input  logic                                pop_valid,
	input  npc_pkg::q_entry_t                   pop_entry,
	output logic                                pop,
	npc_out_if.source                           out_ch
);
	import npc_pkg::*;

	localparam int LEN_W = $clog2(MAX_PATTERN + 1);

	logic [LEN_W-1:0]       blocked_q;
	logic [COUNT_WIDTH-1:0] count_q;
	logic                   out_valid_q;
	logic [COUNT_WIDTH-1:0] out_count_q;
	logic [LEN_W-1:0]       blocked_nxt;
	logic [COUNT_WIDTH-1:0] count_nxt;

	// a last byte waits only while the previous count beat is still held
	assign pop = pop_valid && (!pop_entry.last || !out_valid_q || out_ch.ready);

	always_comb begin
		blocked_nxt = blocked_q;
		count_nxt   = count_q;
		if (blocked_q != '0) begin
			blocked_nxt = blocked_q - 1'b1;
		end else if (pop_entry.hit) begin
			if (count_q != '1) begin
				count_nxt = count_q + 1'b1;
			end
			blocked_nxt = len_eff - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blocked_q   <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			if (pop) begin
				if (pop_entry.last) begin
					blocked_q   <= '0;
					count_q     <= '0;
					out_valid_q <= 1'b1;
				end else begin
					blocked_q <= blocked_nxt;
					count_q   <= count_nxt;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && pop_entry.last) begin
			out_count_q <= count_nxt;
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.match_count = out_count_q;

endmodule

// ===== rtl/core/nonoverlapping_pattern_counter_core.sv =====
// ----------------------------------------------------------------------------
// nonoverlapping_pattern_counter_core: counts non-overlapping pattern hits
// Throughput: one text byte per cycle while the queue is not full, set by
// the combinational window compare. The last byte passes through the queue
// to the back, which registers the count beat once the previous one has left.
// Reset clears all registers but the byte window, queue slots and output count.
// ----------------------------------------------------------------------------
module nonoverlapping_pattern_counter_core #(
	parameter int MAX_PATTERN = 16,
	parameter int COUNT_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	npc_cfg_if.sink     cfg,
	npc_in_if.sink      in_ch,
	npc_out_if.source   out_ch
);
	import npc_pkg::*;

	localparam int LEN_W = $clog2(MAX_PATTERN + 1);

	logic [PAT_W-1:0] pattern;
	logic [LEN_W-1:0] len_eff;
	logic             push;
	q_entry_t         push_entry;
	logic             q_full;
	logic             pop;
	logic             pop_valid;
	q_entry_t         pop_entry;

	npc_cfg_regs #(
		.MAX_PATTERN(MAX_PATTERN)
	) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.pattern (pattern),
		.len_eff (len_eff)
	);

	npc_front #(
		.MAX_PATTERN(MAX_PATTERN)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.pattern    (pattern),
		.len_eff    (len_eff),
		.in_ch      (in_ch),
		.q_full     (q_full),
		.push       (push),
		.push_entry (push_entry)
	);

	npc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.pop_valid  (pop_valid),
		.pop_entry  (pop_entry)
	);

	npc_back #(
		.MAX_PATTERN(MAX_PATTERN),
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.len_eff   (len_eff),
		.pop_valid (pop_valid),
		.pop_entry (pop_entry),
		.pop       (pop),
		.out_ch    (out_ch)
	);

endmodule

// ===== tb/npc_count_checker.sv =====
// ----------------------------------------------------------------------------
// npc_count_checker
// Watches the register, text and count channels of the pattern counter.
// Keeps its own copy of the registers and the per-text window, predicts the
// count of every text and compares it with the count beats that come out.
// ----------------------------------------------------------------------------
module npc_count_checker #(
	parameter int MAX_PATTERN = 16,
	parameter int COUNT_WIDTH = 32
) (
	input  logic clk,
	input  logic arst_n,
	npc_cfg_if   cfg,
	npc_in_if    in_ch,
	npc_out_if   out_ch,
	output int   mismatches,
	output int   counts_waiting,
	output int   counts_checked
);
	import npc_pkg::*;

	localparam int WIN_W = BYTE_W * (MAX_PATTERN + PAT_BYTES);

	logic [CFG_DATA_W-1:0]  pat_lo;
	logic [CFG_DATA_W-1:0]  pat_hi;
	logic [LEN_FIELD_W-1:0] pat_len;
	logic [BYTE_W-1:0]      history [MAX_PATTERN-1];
	int unsigned            seen;
	int unsigned            blocked;
	logic [COUNT_WIDTH-1:0] tally;
	logic [COUNT_WIDTH-1:0] expected_counts [$];
	int                     n_bad;
	int                     n_done;

	always @(posedge clk or negedge arst_n) begin : predict
		int unsigned            eff_len;
		logic                   hit;
		logic [WIN_W-1:0]       pat;
		logic [BYTE_W-1:0]      cur;
		logic [COUNT_WIDTH-1:0] want;
		if (!arst_n) begin
			pat_lo  = '0;
			pat_hi  = '0;
			pat_len = '0;
			for (int k = 0; k < MAX_PATTERN - 1; k++) history[k] = '0;
			seen    = 0;
			blocked = 0;
			tally   = '0;
			expected_counts.delete();
			n_bad   = 0;
			n_done  = 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					CFG_PAT_LO:  pat_lo = cfg.data;
					CFG_PAT_HI:  pat_hi = cfg.data;
					CFG_PAT_LEN: pat_len = cfg.data[LEN_FIELD_W-1:0];
					default: ;
				endcase
			end

			if (out_ch.valid && out_ch.ready) begin
				if (expected_counts.size() == 0) begin
					n_bad++;
					if (n_bad <= 10)
						$display("count beat with no text pending: match_count=%0d",
							out_ch.match_count);
				end else begin
					want = expected_counts.pop_front();
					n_done++;
					if (out_ch.match_count !== want) begin
						n_bad++;
						if (n_bad <= 10)
							$display("match_count mismatch: expected %0d, got %0d",
								want, out_ch.match_count);
					end
				end
			end

			if (in_ch.valid && in_ch.ready) begin
				cur     = in_ch.text_byte;
				eff_len = (pat_len > MAX_PATTERN) ? MAX_PATTERN : pat_len;
				// bytes past the 16 stored ones read as zero
				pat = '0;
				pat[PAT_W-1:0] = {pat_hi, pat_lo};
				if (seen < MAX_PATTERN) seen++;
				if (blocked > 0) begin
					blocked--;
				end else if (eff_len > 0 && seen >= eff_len) begin
					hit = (pat[BYTE_W*(eff_len-1) +: BYTE_W] == cur);
					for (int j = 1; j < eff_len; j++) begin
						if (pat[BYTE_W*(eff_len-1-j) +: BYTE_W] != history[j-1]) hit = 1'b0;
					end
					if (hit) begin
						if (tally != {COUNT_WIDTH{1'b1}}) tally++;
						// hold off matches until the span of this one has passed
						blocked = eff_len - 1;
					end
				end
				for (int k = MAX_PATTERN - 2; k > 0; k--) history[k] = history[k-1];
				history[0] = cur;
				if (in_ch.end_of_text) begin
					expected_counts.push_back(tally);
					for (int k = 0; k < MAX_PATTERN - 1; k++) history[k] = '0;
					seen    = 0;
					blocked = 0;
					tally   = '0;
				end
			end
		end
		mismatches     <= n_bad;
		counts_waiting <= expected_counts.size();
		counts_checked <= n_done;
	end

endmodule

// ===== tb/nonoverlapping_pattern_counter_core_tb.sv =====
// ----------------------------------------------------------------------------
// nonoverlapping_pattern_counter_core_tb
// Drives register writes and texts into the pattern counter, with random
// stalls on both the text and the count side. A short directed part covers
// zero and oversized lengths, short texts, greedy non-overlap and a length
// change inside a text; random phases follow with fresh patterns each time.
// The checker beside the block predicts and compares every count.
// ----------------------------------------------------------------------------
module nonoverlapping_pattern_counter_core_tb;
	import npc_pkg::*;

	localparam int MAX_PATTERN = 16;
	localparam int COUNT_WIDTH = 32;
	localparam int PHASES      = 12;
	localparam int PHASE_BYTES = 108;
	localparam int QUIET_LIMIT = 2000;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	logic clk;
	logic arst_n;

	npc_cfg_if                            cfg();
	npc_in_if                             in_ch();
	npc_out_if #(.COUNT_WIDTH(COUNT_WIDTH)) out_ch();

	int mismatches;
	int counts_waiting;
	int counts_checked;

	nonoverlapping_pattern_counter_core #(
		.MAX_PATTERN(MAX_PATTERN),
		.COUNT_WIDTH(COUNT_WIDTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	npc_count_checker #(
		.MAX_PATTERN(MAX_PATTERN),
		.COUNT_WIDTH(COUNT_WIDTH)
	) checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.mismatches(mismatches),
		.counts_waiting(counts_waiting),
		.counts_checked(counts_checked)
	);

	bit          idle_on;
	bit          stall_on;
	logic [7:0]  text_q [$];
	logic [7:0]  pat_bytes [16];
	int          plen;
	int          bytes_sent;
	int          texts_sent;
	int          reg_writes;
	int          quiet_cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// count beats: ready high, broken by stall bursts while stalls are on
	initial begin
		forever begin
			if (stall_on && $urandom_range(0, 3) == 0) begin
				out_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (cfg.valid && cfg.ready) || (in_ch.valid && in_ch.ready)
				|| (out_ch.valid && out_ch.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("nonoverlapping_pattern_counter_core_tb: errors");
			$finish;
		end
	end

	// leaves cfg.valid high; the caller drops it after the last write
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= value;
		do @(posedge clk); while (!cfg.ready);
		reg_writes++;
	endtask

	task automatic load_pattern(input logic [63:0] lo, input logic [63:0] hi,
			input logic [63:0] len_word);
		write_reg(CFG_PAT_LO, lo);
		write_reg(CFG_PAT_HI, hi);
		write_reg(CFG_PAT_LEN, len_word);
		cfg.valid <= 1'b0;
		for (int k = 0; k < 8; k++) begin
			pat_bytes[k]   = lo[8*k +: 8];
			pat_bytes[k+8] = hi[8*k +: 8];
		end
		plen = (len_word[4:0] > 16) ? 16 : len_word[4:0];
	endtask

	// send the queued bytes; flag the last one only when the text closes here
	task automatic send_text(input bit close);
		for (int i = 0; i < text_q.size(); i++) begin
			if (idle_on && $urandom_range(0, 3) == 0) begin
				in_ch.valid <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
			in_ch.valid       <= 1'b1;
			in_ch.text_byte   <= text_q[i];
			in_ch.end_of_text <= close && (i == text_q.size() - 1);
			do @(posedge clk); while (!in_ch.ready);
			bytes_sent++;
		end
		if (close) texts_sent++;
		text_q.delete();
	endtask

	// wait for every pending count, then let the pipeline empty
	task automatic settle();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (counts_waiting != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin : stimulus
		int          target;
		int          pick;
		int          phase_bytes;
		logic [7:0]  sym [2];
		logic [63:0] lo;
		logic [63:0] hi;
		logic [4:0]  len;
		bit          narrow;

		arst_n            <= 1'b0;
		cfg.valid         <= 1'b0;
		cfg.index         <= CFG_PAT_LO;
		cfg.data          <= '0;
		in_ch.valid       <= 1'b0;
		in_ch.text_byte   <= '0;
		in_ch.end_of_text <= 1'b0;
		idle_on    = 1'b0;
		stall_on   = 1'b0;
		bytes_sent = 0;
		texts_sent = 0;
		reg_writes = 0;
		plen       = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// zero length straight out of reset
		text_q = '{8'h00};
		send_text(1);
		settle();

		// greedy non-overlap: five A's hold two AA's
		load_pattern(64'h4141, 64'h0, 64'd2);
		text_q = '{8'h41, 8'h41, 8'h41, 8'h41, 8'h41};
		send_text(1);
		settle();

		// length 1 with junk above the length field
		load_pattern(64'h00FF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFE1);
		text_q = '{8'hFF, 8'h00, 8'hFF};
		send_text(1);
		settle();

		// text shorter than the pattern
		load_pattern(64'hFF_FFFF, 64'h0, 64'd3);
		text_q = '{8'hFF, 8'hFF};
		send_text(1);
		settle();

		// oversized length clamps to the maximum
		load_pattern({$urandom, $urandom}, {$urandom, $urandom}, 64'd31);
		text_q = '{8'hFF};
		send_text(1);
		settle();

		// length change inside a text: window and hold-off carry over
		load_pattern(64'h4241, 64'h0, 64'd2);
		text_q = '{8'h41, 8'h42};
		send_text(0);
		settle();
		write_reg(CFG_PAT_LEN, 64'd1);
		cfg.valid <= 1'b0;
		plen = 1;
		text_q = '{8'h41, 8'h41};
		send_text(1);
		settle();

		// a write to the unused index changes nothing
		write_reg(CFG_SPARE, {$urandom, $urandom});
		cfg.valid <= 1'b0;
		text_q = '{8'h41};
		send_text(1);
		settle();

		for (int ph = 0; ph < PHASES; ph++) begin
			narrow = ($urandom_range(0, 3) != 0);
			sym[0] = 8'($urandom_range(0, 255));
			sym[1] = sym[0] ^ (8'h01 << $urandom_range(0, 7));
			if (ph == 0) begin
				narrow = 1'b1;
				sym[0] = 8'hFF;
				sym[1] = 8'h00;
			end
			lo = {$urandom, $urandom};
			hi = {$urandom, $urandom};
			if (narrow) begin
				for (int k = 0; k < 8; k++) begin
					lo[8*k +: 8] = sym[$urandom_range(0, 1)];
					hi[8*k +: 8] = sym[$urandom_range(0, 1)];
				end
			end
			case (ph)
				0: begin
					len = 5'd16;
					lo  = '1;
					hi  = '1;
				end
				1: len = 5'd1;
				2: len = 5'd31;
				3: len = 5'd0;
				default: len = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(17, 31))
					: 5'($urandom_range(0, 16));
			endcase
			load_pattern(lo, hi, {59'd0, len});
			// quiet handshakes for the last phases and for some others
			idle_on  = (ph < PHASES - 2) && ($urandom_range(0, 4) != 0);
			stall_on = idle_on;

			phase_bytes = 0;
			while (phase_bytes < PHASE_BYTES) begin
				if ($urandom_range(0, 3) == 0) begin
					repeat ($urandom_range(1, 20))
						text_q.push_back(8'($urandom_range(0, 255)));
				end else begin
					target = $urandom_range(1, 3 * plen + 12);
					while (text_q.size() < target) begin
						pick = $urandom_range(0, 9);
						if (pick < 5 && plen > 0) begin
							for (int k = 0; k < plen; k++) text_q.push_back(pat_bytes[k]);
						end else if (pick < 7 && plen > 1) begin
							for (int k = 0; k <= $urandom_range(0, plen - 2); k++)
								text_q.push_back(pat_bytes[k]);
						end else if (narrow) begin
							text_q.push_back(sym[$urandom_range(0, 1)]);
						end else begin
							text_q.push_back(8'($urandom_range(0, 255)));
						end
					end
				end
				phase_bytes += text_q.size();
				send_text(1);
			end
			settle();
		end

		$display("%0d text bytes in %0d texts, %0d register writes, %0d counts checked",
			bytes_sent, texts_sent, reg_writes, counts_checked);
		$display("lengths 0 to 16 and clamped, two-symbol and full-range texts, with stalls");
		if (mismatches == 0) begin
			$display("nonoverlapping_pattern_counter_core_tb: clean");
		end else begin
			$display("nonoverlapping_pattern_counter_core_tb: errors");
		end
		$finish;
	end

endmodule
